// ===== rtl/stk_pkg.sv =====
// Shared types, token kinds and character helpers for the script token scanner.
`timescale 1ns / 1ps
package stk_pkg;

	localparam int OffsetBitsDef = 16;
	localparam int LineBitsDef   = 16;
	localparam int QueueDepth    = 4;
	localparam int MaxTokens     = 4;

	localparam logic [5:0] KIND_END     = 6'd0;
	localparam logic [5:0] KIND_LPAREN  = 6'd1;
	localparam logic [5:0] KIND_RPAREN  = 6'd2;
	localparam logic [5:0] KIND_LBRACE  = 6'd3;
	localparam logic [5:0] KIND_RBRACE  = 6'd4;
	localparam logic [5:0] KIND_COMMA   = 6'd5;
	localparam logic [5:0] KIND_MINUS   = 6'd6;
	localparam logic [5:0] KIND_PLUS    = 6'd7;
	localparam logic [5:0] KIND_SEMI    = 6'd8;
	localparam logic [5:0] KIND_COLON   = 6'd9;
	localparam logic [5:0] KIND_STAR    = 6'd10;
	localparam logic [5:0] KIND_SLASH   = 6'd11;
	localparam logic [5:0] KIND_PERCENT = 6'd12;
	localparam logic [5:0] KIND_HASH    = 6'd13;
	localparam logic [5:0] KIND_NOT     = 6'd14;
	localparam logic [5:0] KIND_ASSIGN  = 6'd16;
	localparam logic [5:0] KIND_LT      = 6'd18;
	localparam logic [5:0] KIND_GT      = 6'd20;
	localparam logic [5:0] KIND_INT     = 6'd22;
	localparam logic [5:0] KIND_DECIMAL = 6'd23;
	localparam logic [5:0] KIND_RANK    = 6'd24;
	localparam logic [5:0] KIND_DIFF    = 6'd25;
	localparam logic [5:0] KIND_TSTAMP  = 6'd26;
	localparam logic [5:0] KIND_IDENT   = 6'd27;
	localparam logic [5:0] KIND_TABLE   = 6'd28;
	localparam logic [5:0] KIND_LABEL   = 6'd29;
	localparam logic [5:0] KIND_BIND    = 6'd30;
	localparam logic [5:0] KIND_ERROR   = 6'd36;

	localparam logic [2:0] KW_NONE  = 3'd0;
	localparam logic [2:0] KW_BIND  = 3'd1;
	localparam logic [2:0] KW_ELSE  = 3'd2;
	localparam logic [2:0] KW_IF    = 3'd3;
	localparam logic [2:0] KW_LOOP  = 3'd4;
	localparam logic [2:0] KW_SUB   = 3'd5;
	localparam logic [2:0] KW_WHILE = 3'd6;

	typedef enum logic [3:0] {
		MODE_IDLE, MODE_MINUS, MODE_INT, MODE_INT_DOT, MODE_FRAC, MODE_RD_PEND,
		MODE_RD_RUN, MODE_IDENT, MODE_DOLLAR, MODE_TABLE, MODE_AT, MODE_LABEL,
		MODE_TSTAMP, MODE_OP, MODE_SLASH, MODE_COMMENT
	} mode_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] line;
		logic        stray;
	} tok_t;

	typedef struct packed {
		tok_t [MaxTokens-1:0] tok;
		logic [2:0]           cnt;
	} bundle_t;

	typedef struct packed {
		tok_t       t0;
		tok_t       t1;
		logic [1:0] n;
	} fin_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_digit(c) || is_alpha(c);
	endfunction

	function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [1:0] inc);
		logic [16:0] s;
		s = 17'(a) + 17'(inc);
		return (s > 17'h0FFFF) ? 16'hFFFF : s[15:0];
	endfunction

	function automatic logic [2:0] kw_len(input logic [2:0] k);
		case (k)
			KW_BIND, KW_ELSE, KW_LOOP: return 3'd4;
			KW_IF:    return 3'd2;
			KW_SUB:   return 3'd3;
			KW_WHILE: return 3'd5;
			default:  return 3'd0;
		endcase
	endfunction

	function automatic logic [39:0] kw_text(input logic [2:0] k);
		case (k)
			KW_BIND:  return {8'h00, "dnib"};
			KW_ELSE:  return {8'h00, "esle"};
			KW_IF:    return {24'h0, "fi"};
			KW_LOOP:  return {8'h00, "pool"};
			KW_SUB:   return {16'h0, "bus"};
			KW_WHILE: return "elihw";
			default:  return 40'h0;
		endcase
	endfunction

	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] i);
		logic [39:0] t;
		t = kw_text(k);
		case (i)
			3'd0:    return t[7:0];
			3'd1:    return t[15:8];
			3'd2:    return t[23:16];
			3'd3:    return t[31:24];
			3'd4:    return t[39:32];
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [5:0] op_kind(input logic [7:0] h);
		case (h)
			"!":     return KIND_NOT;
			"=":     return KIND_ASSIGN;
			"<":     return KIND_LT;
			default: return KIND_GT;
		endcase
	endfunction

	function automatic tok_t make_tok(input logic [5:0] kind, input logic [15:0] start,
		input logic [15:0] len, input logic [15:0] line, input logic stray);
		tok_t t;
		t.kind  = kind;
		t.start = start;
		t.len   = len;
		t.line  = line;
		t.stray = stray;
		return t;
	endfunction

	function automatic fin_t finish(input mode_t m, input logic [15:0] start,
		input logic [15:0] len, input logic [2:0] kwp, input logic [7:0] held,
		input logic [15:0] dot, input logic [15:0] line);
		fin_t f;
		logic [5:0] ik;
		ik = (kwp != KW_NONE && kwp <= KW_WHILE && len == 16'(kw_len(kwp)))
			? 6'(KIND_BIND + 6'(kwp) - 6'd1) : KIND_IDENT;
		f.t0 = make_tok(KIND_ERROR, start, 16'd1, line, 1'b0);
		f.t1 = make_tok(KIND_ERROR, dot, 16'd1, line, 1'b0);
		f.n  = 2'd1;
		case (m)
			MODE_MINUS:   f.t0.kind = KIND_MINUS;
			MODE_INT:     f.t0 = make_tok(KIND_INT, start, len, line, 1'b0);
			MODE_INT_DOT: begin
				f.t0 = make_tok(KIND_INT, start, len, line, 1'b0);
				f.n  = 2'd2;
			end
			MODE_FRAC:    f.t0 = make_tok(KIND_DECIMAL, start, len, line, 1'b0);
			MODE_RD_PEND: f.t0 = make_tok(KIND_IDENT, start, len, line, 1'b0);
			MODE_RD_RUN:  f.t0 = make_tok((held == "r") ? KIND_RANK : KIND_DIFF,
				start, len, line, 1'b0);
			MODE_IDENT:   f.t0 = make_tok(ik, start, len, line, 1'b0);
			MODE_DOLLAR, MODE_AT: f.t0.kind = KIND_ERROR;
			MODE_TABLE:   f.t0 = make_tok(KIND_TABLE, start, len, line, 1'b0);
			MODE_LABEL:   f.t0 = make_tok(KIND_LABEL, start, len, line, 1'b0);
			MODE_TSTAMP:  f.t0 = make_tok(KIND_TSTAMP, start, len, line, 1'b0);
			MODE_OP:      f.t0.kind = op_kind(held);
			MODE_SLASH:   f.t0.kind = KIND_SLASH;
			default:      f.n = 2'd0;
		endcase
		return f;
	endfunction

endpackage

// ===== rtl/stk_front.sv =====
// Front end: scans one byte per cycle while take is high and gathers the tokens it completes into a bundle.
`timescale 1ns / 1ps
module stk_front #(
	parameter int OFFSET_BITS = stk_pkg::OffsetBitsDef,
	parameter int LINE_BITS   = stk_pkg::LineBitsDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       char_code,
	input  logic             end_of_source,
	output logic             push,
	output stk_pkg::bundle_t bundle
);
	import stk_pkg::*;

	localparam logic [LINE_BITS-1:0] LineTop = '1;

	mode_t                  mode_q, m;
	logic [OFFSET_BITS-1:0] begin_q, pos_q, b, pos_n;
	logic [LINE_BITS-1:0]   line_q, ln;
	logic [2:0]             kwp_q, k;
	logic [7:0]             held_q, h;
	logic [15:0]            len_q, l;
	logic                   ext;
	logic [2:0]             n;
	logic [31:0]            w_begin, w_begin_n, w_pos, w_pos_n, w_line_q, w_line_n;
	logic [15:0]            line16_q, line16_n;
	fin_t                   f1, f2;

	always_comb begin
		w_begin   = 32'(begin_q);
		w_pos     = 32'(pos_q - OFFSET_BITS'(1));
		w_line_q  = 32'(line_q);
		line16_q  = (w_line_q > 32'h0000FFFF) ? 16'hFFFF : w_line_q[15:0];
		m = mode_q; b = begin_q; l = len_q; k = kwp_q; h = held_q; ln = line_q;
		ext = 1'b0;
		n = 3'd0;
		bundle.tok = '0;
		case (mode_q)
			MODE_MINUS: if (is_digit(char_code)) begin
				m = MODE_INT; l = sat_add(len_q, 2'd1); ext = 1'b1;
			end
			MODE_INT: if (is_digit(char_code)) begin
				l = sat_add(len_q, 2'd1); ext = 1'b1;
			end else if (char_code == ".") begin
				m = MODE_INT_DOT; ext = 1'b1;
			end
			MODE_INT_DOT: if (is_digit(char_code)) begin
				m = MODE_FRAC; l = sat_add(len_q, 2'd2); ext = 1'b1;
			end
			MODE_FRAC, MODE_RD_RUN, MODE_TSTAMP: if (is_digit(char_code)) begin
				l = sat_add(len_q, 2'd1); ext = 1'b1;
			end
			MODE_RD_PEND: if (is_digit(char_code)) begin
				m = MODE_RD_RUN; l = sat_add(len_q, 2'd1); ext = 1'b1;
			end else if (is_alnum(char_code)) begin
				m = MODE_IDENT; k = KW_NONE; l = sat_add(len_q, 2'd1); ext = 1'b1;
			end
			MODE_IDENT: if (is_alnum(char_code)) begin
				if (!(kwp_q != KW_NONE && kwp_q <= KW_WHILE
					&& len_q < 16'(kw_len(kwp_q))
					&& kw_char(kwp_q, len_q[2:0]) == char_code)) begin
					k = KW_NONE;
				end
				l = sat_add(len_q, 2'd1); ext = 1'b1;
			end
			MODE_DOLLAR: if (is_alnum(char_code)) begin
				m = MODE_TABLE; l = sat_add(len_q, 2'd1); ext = 1'b1;
			end
			MODE_TABLE, MODE_LABEL: if (is_alnum(char_code)) begin
				l = sat_add(len_q, 2'd1); ext = 1'b1;
			end
			MODE_AT: if (is_alpha(char_code)) begin
				m = MODE_LABEL; l = sat_add(len_q, 2'd1); ext = 1'b1;
			end else if (char_code == "+" || char_code == "-" || is_digit(char_code)) begin
				m = MODE_TSTAMP; l = sat_add(len_q, 2'd1); ext = 1'b1;
			end
			MODE_OP: if (char_code == "=") begin
				bundle.tok[0] = make_tok(6'(op_kind(held_q) + 6'd1), w_begin[15:0],
					16'd2, line16_q, 1'b0);
				n = 3'd1; m = MODE_IDLE; ext = 1'b1;
			end
			MODE_SLASH: if (char_code == "/") begin
				m = MODE_COMMENT; ext = 1'b1;
			end
			MODE_COMMENT: ext = (char_code != 8'h0A);
			default: ext = 1'b0;
		endcase

		f1 = finish(mode_q, w_begin[15:0], len_q, kwp_q, held_q, w_pos[15:0], line16_q);
		if (!ext) begin
			if (f1.n != 2'd0) begin
				bundle.tok[n[1:0]] = f1.t0; n = n + 3'd1;
			end
			if (f1.n == 2'd2) begin
				bundle.tok[n[1:0]] = f1.t1; n = n + 3'd1;
			end
			b = pos_q; l = 16'd1; k = KW_NONE; m = MODE_IDLE;
			case (char_code)
				" ", 8'h0D, 8'h09: m = MODE_IDLE;
				8'h0A: if (line_q != LineTop) ln = line_q + LINE_BITS'(1);
				"(", ")", "{", "}", ",", "+", ";", ":", "*", "%", "#", ".": begin
					bundle.tok[n[1:0]] = make_tok(KIND_ERROR, 16'(32'(pos_q)), 16'd1,
						line16_q, 1'b0);
					case (char_code)
						"(":     bundle.tok[n[1:0]].kind = KIND_LPAREN;
						")":     bundle.tok[n[1:0]].kind = KIND_RPAREN;
						"{":     bundle.tok[n[1:0]].kind = KIND_LBRACE;
						"}":     bundle.tok[n[1:0]].kind = KIND_RBRACE;
						",":     bundle.tok[n[1:0]].kind = KIND_COMMA;
						"+":     bundle.tok[n[1:0]].kind = KIND_PLUS;
						";":     bundle.tok[n[1:0]].kind = KIND_SEMI;
						":":     bundle.tok[n[1:0]].kind = KIND_COLON;
						"*":     bundle.tok[n[1:0]].kind = KIND_STAR;
						"%":     bundle.tok[n[1:0]].kind = KIND_PERCENT;
						"#":     bundle.tok[n[1:0]].kind = KIND_HASH;
						default: bundle.tok[n[1:0]].kind = KIND_ERROR;
					endcase
					n = n + 3'd1;
				end
				"-": m = MODE_MINUS;
				"$": m = MODE_DOLLAR;
				"@": m = MODE_AT;
				"/": m = MODE_SLASH;
				"!", "=", "<", ">": begin
					h = char_code; m = MODE_OP;
				end
				"r", "d": begin
					h = char_code; m = MODE_RD_PEND;
				end
				default: begin
					if (is_alpha(char_code)) begin
						m = MODE_IDENT;
						case (char_code)
							"b":     k = KW_BIND;
							"e":     k = KW_ELSE;
							"i":     k = KW_IF;
							"l":     k = KW_LOOP;
							"s":     k = KW_SUB;
							"w":     k = KW_WHILE;
							default: k = KW_NONE;
						endcase
					end else if (is_digit(char_code)) begin
						m = MODE_INT;
					end else begin
						bundle.tok[n[1:0]] = make_tok(KIND_ERROR, 16'(32'(pos_q)), 16'd1,
							line16_q, 1'b1);
						n = n + 3'd1;
					end
				end
			endcase
		end

		pos_n     = pos_q + OFFSET_BITS'(1);
		w_begin_n = 32'(b);
		w_pos_n   = 32'(pos_n);
		w_line_n  = 32'(ln);
		line16_n  = (w_line_n > 32'h0000FFFF) ? 16'hFFFF : w_line_n[15:0];
		f2 = finish(m, w_begin_n[15:0], l, k, h, 16'(32'(pos_q)), line16_n);
		if (end_of_source) begin
			if (f2.n != 2'd0) begin
				bundle.tok[n[1:0]] = f2.t0; n = n + 3'd1;
			end
			if (f2.n == 2'd2) begin
				bundle.tok[n[1:0]] = f2.t1; n = n + 3'd1;
			end
			bundle.tok[n[1:0]] = make_tok(KIND_END, w_pos_n[15:0], 16'd0, line16_n, 1'b0);
			n = n + 3'd1;
		end
		bundle.cnt = n;
		push = take && (n != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			begin_q <= '0;
			pos_q <= '0;
			line_q <= LINE_BITS'(1);
			kwp_q <= KW_NONE;
			held_q <= 8'h00;
			len_q <= 16'd0;
		end else if (take) begin
			if (end_of_source) begin
				mode_q <= MODE_IDLE;
				begin_q <= '0;
				pos_q <= '0;
				line_q <= LINE_BITS'(1);
				kwp_q <= KW_NONE;
				held_q <= 8'h00;
				len_q <= 16'd0;
			end else begin
				mode_q <= m;
				begin_q <= b;
				pos_q <= pos_n;
				line_q <= ln;
				kwp_q <= k;
				held_q <= h;
				len_q <= l;
			end
		end
	end

endmodule

// ===== rtl/stk_queue.sv =====
// Short queue of token bundles between the scanner and the token sender.
`timescale 1ns / 1ps
module stk_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  stk_pkg::bundle_t push_data,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output stk_pkg::bundle_t head
);
	import stk_pkg::*;

	localparam int PtrBits = $clog2(QueueDepth);

	bundle_t              store_q [QueueDepth];
	logic [PtrBits-1:0]   wr_q, rd_q;
	logic [PtrBits:0]     count_q;

	assign full       = (count_q == (PtrBits + 1)'(QueueDepth));
	assign head_valid = (count_q != '0);
	assign head       = store_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PtrBits'(1);
			if (pop) rd_q <= rd_q + PtrBits'(1);
			if (push && !pop) count_q <= count_q + (PtrBits + 1)'(1);
			else if (pop && !push) count_q <= count_q - (PtrBits + 1)'(1);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("bundle pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop) else $error("bundle popped from an empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PtrBits + 1)'(QueueDepth)) else $error("queue count out of range");
`endif

endmodule

// ===== rtl/stk_back.sv =====
// Back end: sends the tokens of each bundle one word at a time and marks the last one.
`timescale 1ns / 1ps
module stk_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  stk_pkg::bundle_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output stk_pkg::tok_t    out_tok,
	output logic             out_last
);
	import stk_pkg::*;

	bundle_t    cur_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       fire, done;

	assign out_valid = busy_q;
	assign out_tok   = cur_q.tok[idx_q];
	assign out_last  = ((3'(idx_q) + 3'd1) == cur_q.cnt);
	assign fire      = busy_q && out_ready;
	assign done      = !busy_q || (fire && out_last);
	assign pop       = done && head_valid;

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (done) begin
			busy_q <= head_valid;
			idx_q <= 2'd0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

`ifndef SYNTHESIS
	a_idx_in_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (3'(idx_q) < cur_q.cnt)) else $error("token index past bundle end");
	a_bundle_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cur_q.cnt != 3'd0)) else $error("empty bundle in sender");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !out_last) |=> (busy_q && idx_q == $past(idx_q) + 2'd1))
		else $error("sender skipped a token");
`endif

endmodule

// ===== rtl/script_token_scanner.sv =====
// Top level of the script token scanner: scanner front end, bundle queue and token sender.
//
// The scanner takes one source byte per cycle and turns it into zero to four tokens
// (a completed pending token, a possible dot error, a single-byte token and, on the
// last byte, the end token), which go as one bundle into a four-entry queue. The
// sender delivers one token word per cycle while m_tready is high; the input stalls only
// while the queue is full, i.e. when the output drains slower than bytes produce tokens.
`timescale 1ns / 1ps
module script_token_scanner #(
	parameter int OFFSET_BITS = stk_pkg::OffsetBitsDef,
	parameter int LINE_BITS   = stk_pkg::LineBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code
	input  logic        s_tlast,   // end_of_source
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // token_kind, token_start, token_length, line_number, zero pad
	output logic        m_tuser,   // unexpected_char
	output logic        m_tlast    // last_of_run
);
	import stk_pkg::*;

	logic    take, push, full, head_valid, pop;
	bundle_t bundle, head;
	tok_t    tok;

	assign s_tready = !full;
	assign take     = s_tvalid && s_tready;

	stk_front #(
		.OFFSET_BITS(OFFSET_BITS),
		.LINE_BITS(LINE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.char_code(s_tdata),
		.end_of_source(s_tlast),
		.push(push),
		.bundle(bundle)
	);

	stk_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(bundle),
		.pop(pop),
		.full(full),
		.head_valid(head_valid),
		.head(head)
	);

	stk_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_tok(tok),
		.out_last(m_tlast)
	);

	assign m_tdata = {2'b00, tok.line, tok.len, tok.start, tok.kind};
	assign m_tuser = tok.stray;

endmodule
